### src/utept_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and microcode encodings for the uart transmit-enable pulse timer
// no dependencies

package utept_pkg;

    localparam int TIME_WIDTH_DEF = 32;

    localparam int NOW_W   = 32;
    localparam int BYTES_W = 16;
    localparam int BAUD_W  = 24;
    localparam int END_W   = 32;
    localparam int DUR_W   = 32;

    // bytes * 10 bits * 1e6 us stays below 2^40
    localparam int PROD_W = 40;
    localparam int DIV_CNT_W = $clog2(PROD_W);
    localparam logic [BAUD_W-1:0] BIT_US_K = BAUD_W'(10 * 1000000);
    localparam int GUARD_US = 20;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_WAIT    = 4'd0;
    localparam t_step STEP_DECODE  = 4'd1;
    localparam t_step STEP_PIN     = 4'd2;
    localparam t_step STEP_MUL     = 4'd3;
    localparam t_step STEP_DIVINIT = 4'd4;
    localparam t_step STEP_DIV     = 4'd5;
    localparam t_step STEP_START   = 4'd6;
    localparam t_step STEP_UPDATE  = 4'd7;
    localparam t_step STEP_OUT     = 4'd8;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_START,
        OP_UPDATE,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_UPDATE,
        C_NO_PIN,
        C_ZERO,
        C_DIV_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic no_in;
        logic update;
        logic no_pin;
        logic zero;
        logic div_more;
        logic out_busy;
    } t_flags;

endpackage

### src/utept_seq.sv
`timescale 1ns / 1ps
// microcode sequencer: step counter, control store and conditional jump
// depends on utept_pkg

module utept_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  utept_pkg::t_flags i_flags,
    output utept_pkg::t_uword o_uword,
    output logic              o_wait
);
    import utept_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   take_jump;

    // control store
    always_comb begin
        unique case (r_step)
            STEP_WAIT:    uw = '{op: OP_LOAD,    cond: C_NO_IN,    target: STEP_WAIT};
            STEP_DECODE:  uw = '{op: OP_NOP,     cond: C_UPDATE,   target: STEP_UPDATE};
            STEP_PIN:     uw = '{op: OP_NOP,     cond: C_NO_PIN,   target: STEP_OUT};
            STEP_MUL:     uw = '{op: OP_MUL,     cond: C_NEVER,    target: STEP_WAIT};
            STEP_DIVINIT: uw = '{op: OP_DIVINIT, cond: C_ZERO,     target: STEP_START};
            STEP_DIV:     uw = '{op: OP_DIVSTEP, cond: C_DIV_MORE, target: STEP_DIV};
            STEP_START:   uw = '{op: OP_START,   cond: C_ALWAYS,   target: STEP_OUT};
            STEP_UPDATE:  uw = '{op: OP_UPDATE,  cond: C_NEVER,    target: STEP_WAIT};
            STEP_OUT:     uw = '{op: OP_OUT,     cond: C_OUT_BUSY, target: STEP_OUT};
            default:      uw = '{op: OP_NOP,     cond: C_ALWAYS,   target: STEP_WAIT};
        endcase
    end

    always_comb begin
        unique case (uw.cond)
            C_NEVER:    take_jump = 1'b0;
            C_ALWAYS:   take_jump = 1'b1;
            C_NO_IN:    take_jump = i_flags.no_in;
            C_UPDATE:   take_jump = i_flags.update;
            C_NO_PIN:   take_jump = i_flags.no_pin;
            C_ZERO:     take_jump = i_flags.zero;
            C_DIV_MORE: take_jump = i_flags.div_more;
            C_OUT_BUSY: take_jump = i_flags.out_busy;
            default:    take_jump = 1'b1;
        endcase
    end

    // the output step falls through to the top of the program
    always_comb begin
        if (take_jump) begin
            n_step = uw.target;
        end else if (r_step == STEP_OUT) begin
            n_step = STEP_WAIT;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uword = uw;
    assign o_wait  = (r_step == STEP_WAIT);

endmodule

### src/uart_tx_enable_pulse_timer_top.sv
`timescale 1ns / 1ps
// top level of the uart transmit-enable pulse timer: datapath, config and result register
// depends on utept_pkg and utept_seq

// Every accepted beat gives exactly one result beat. A start event with the
// pin register set runs the bit-serial restoring divider, one quotient bit per
// cycle, to work out the frame time before its result is loaded into the
// output register. A start event with zero bytes or zero baud skips the
// divider; a start event without a pin and an update event skip both the
// multiply and the divider.
// The next beat can be accepted on the cycle after the result is loaded.
// The input is stalled while an event is in work; the result register lets
// the next event enter while the previous result waits to be taken.
module uart_tx_enable_pulse_timer_top #(
    parameter int TIME_WIDTH = utept_pkg::TIME_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [utept_pkg::NOW_W-1:0]   i_now_us,
    input  logic [utept_pkg::BYTES_W-1:0] i_byte_count,
    input  logic [utept_pkg::BAUD_W-1:0]  i_baud,
    input  logic                          i_buffer_empty,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_pin_level,
    output logic [utept_pkg::END_W-1:0]   o_end_time_us
);
    import utept_pkg::*;

    t_uword uw;
    t_flags flags;
    logic   seq_wait;

    logic r_pin_present;
    logic r_pulse_active;
    logic [TIME_WIDTH-1:0] r_pulse_end;

    // latched event
    logic                r_mode;
    logic [TIME_WIDTH-1:0] r_now;
    logic [BYTES_W-1:0]  r_bytes;
    logic [BAUD_W-1:0]   r_baud;
    logic                r_empty;
    logic                r_zero;

    logic [PROD_W-1:0]    r_prod;
    logic [PROD_W-1:0]    r_quo;
    logic [BAUD_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic              r_out_valid;
    logic              r_out_pin;
    logic [END_W-1:0]  r_out_end;

    logic [BAUD_W:0]     rem_shift;
    logic                rem_take;
    logic [DUR_W-1:0]    dur;
    logic [TIME_WIDTH-1:0] diff;
    logic                out_free;
    logic                in_acc;

    utept_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw),
        .o_wait  (seq_wait)
    );

    assign o_in_stall = !seq_wait;
    assign in_acc     = i_in_valid && seq_wait;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        flags.no_in    = !i_in_valid;
        flags.update   = r_mode;
        flags.no_pin   = !r_pin_present;
        flags.zero     = r_zero;
        flags.div_more = (r_div_cnt != '0);
        flags.out_busy = !out_free;
    end

    // one restoring divide step
    assign rem_shift = {r_rem, r_quo[PROD_W-1]};
    assign rem_take  = (rem_shift >= {1'b0, r_baud});
    assign dur       = r_zero ? '0 : r_quo[DUR_W-1:0];
    assign diff      = r_now - r_pulse_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_present <= 1'b0;
        end else if (i_cfg_we) begin
            r_pin_present <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.op == OP_LOAD && in_acc) begin
            r_mode  <= i_mode;
            r_now   <= TIME_WIDTH'(i_now_us);
            r_bytes <= i_byte_count;
            r_baud  <= i_baud;
            r_empty <= i_buffer_empty;
            r_zero  <= (i_byte_count == '0) || (i_baud == '0);
        end
        if (uw.op == OP_MUL) begin
            r_prod <= PROD_W'(r_bytes) * PROD_W'(BIT_US_K);
        end
        if (uw.op == OP_DIVINIT) begin
            // ceiling: add divisor minus one before dividing
            r_quo <= r_prod + PROD_W'(r_baud) - PROD_W'(1);
            r_rem <= '0;
        end
        if (uw.op == OP_DIVSTEP) begin
            r_quo <= {r_quo[PROD_W-2:0], rem_take};
            r_rem <= rem_take ? BAUD_W'(rem_shift - {1'b0, r_baud}) : BAUD_W'(rem_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (uw.op == OP_DIVINIT) begin
            r_div_cnt <= DIV_CNT_W'(PROD_W - 1);
        end else if (uw.op == OP_DIVSTEP && r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_active <= 1'b0;
            r_pulse_end    <= '0;
        end else if (uw.op == OP_START) begin
            r_pulse_active <= 1'b1;
            r_pulse_end    <= r_now + TIME_WIDTH'(dur) + TIME_WIDTH'(GUARD_US);
        end else if (uw.op == OP_UPDATE) begin
            // drop once drained and the end time has been reached
            if (r_pulse_active && r_empty && !diff[TIME_WIDTH-1]) begin
                r_pulse_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.op == OP_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.op == OP_OUT && out_free) begin
            r_out_pin <= r_pulse_active;
            r_out_end <= END_W'(r_pulse_end);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pin_level   = r_out_pin;
    assign o_end_time_us = r_out_end;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled after an accepted beat");

    a_rise_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pulse_active) |-> $past(uw.op == OP_START))
        else $error("pulse raised outside a start step");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(uw.op == OP_OUT))
        else $error("result beat without output step");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == OP_DIVSTEP && r_div_cnt != '0)
            |=> (r_div_cnt == $past(r_div_cnt) - DIV_CNT_W'(1)))
        else $error("divider count did not advance");
`endif

endmodule
